// ===== rtl/chm_pkg.sv =====
package chm_pkg;

   localparam int KEY_BITS = 32;
   localparam int OUT_BITS = 32;

   // func codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   // sequencer -> datapath
   typedef struct packed {
      logic clear_step;   // write empty marker to next bucket head
      logic capture;      // latch request, read bucket head
      logic load_head;    // read node at bucket head
      logic follow_next;  // read node at next pointer
      logic finish;       // commit result (and insert)
      logic hit;          // key found on the walk
   } chm_cmd_type;

   // datapath -> sequencer
   typedef struct packed {
      logic clear_done;
      logic head_null;
      logic key_match;
      logic next_null;
   } chm_sts_type;

endpackage

// ===== rtl/chm_ctrl.sv =====
module chm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  chm_pkg::chm_sts_type sts,
   output chm_pkg::chm_cmd_type cmd,
   output logic                 busy
);
   import chm_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_HEAD  = 2'd2;
   localparam logic [1:0] S_NODE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_HEAD;
            end
         end
         S_HEAD: begin
            if (sts.head_null) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.load_head = 1'b1;
               state_in      = S_NODE;
            end
         end
         S_NODE: begin
            if (sts.key_match) begin
               cmd.finish = 1'b1;
               cmd.hit    = 1'b1;
               state_in   = S_IDLE;
            end else if (sts.next_null) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.follow_next = 1'b1;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== rtl/chm_datapath.sv =====
module chm_datapath #(
   parameter int BUCKETS    = 64,
   parameter int ENTRIES    = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  chm_pkg::chm_cmd_type         cmd,
   output chm_pkg::chm_sts_type         sts,
   input  logic                         req_func,
   input  logic [chm_pkg::KEY_BITS-1:0] req_key,
   input  logic [chm_pkg::KEY_BITS-1:0] req_value,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [chm_pkg::OUT_BITS-1:0] rsp_value_out
);
   import chm_pkg::*;

   localparam int BW = $clog2(BUCKETS);
   localparam int NW = $clog2(ENTRIES);
   localparam int PW = $clog2(ENTRIES + 1);   // pointer incl. null marker
   localparam int VW = (VALUE_BITS < OUT_BITS) ? VALUE_BITS : OUT_BITS;
   localparam logic [PW-1:0] NIL = PW'(ENTRIES);

   logic [PW-1:0]       head_mem [BUCKETS];
   logic [KEY_BITS-1:0] key_mem  [ENTRIES];
   logic [VW-1:0]       val_mem  [ENTRIES];
   logic [PW-1:0]       next_mem [ENTRIES];

   logic                func_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [VW-1:0]       value_ff;
   logic [BW-1:0]       clr_cnt_ff;
   logic [PW-1:0]       count_ff;
   logic [PW-1:0]       head_rd_ff;
   logic [KEY_BITS-1:0] nkey_rd_ff;
   logic [VW-1:0]       nval_rd_ff;
   logic [PW-1:0]       nnext_rd_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   logic [OUT_BITS-1:0] rsp_value_out_ff;

   logic                full;
   logic                ins_ok;
   logic                head_we;
   logic [BW-1:0]       head_wa;
   logic [PW-1:0]       head_wd;
   logic [NW-1:0]       node_ra;

   assign full   = (count_ff == NIL);
   assign ins_ok = cmd.finish && (func_ff == FUNC_INSERT) && !cmd.hit && !full;

   assign head_we = cmd.clear_step || ins_ok;
   assign head_wa = cmd.clear_step ? clr_cnt_ff : key_ff[BW-1:0];
   assign head_wd = cmd.clear_step ? NIL : count_ff;
   assign node_ra = cmd.load_head ? head_rd_ff[NW-1:0] : nnext_rd_ff[NW-1:0];

   assign sts.clear_done = (clr_cnt_ff == BW'(BUCKETS - 1));
   assign sts.head_null  = (head_rd_ff >= NIL);
   assign sts.key_match  = (nkey_rd_ff == key_ff);
   assign sts.next_null  = (nnext_rd_ff >= NIL);

   // bucket head table
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      if (cmd.capture) head_rd_ff <= head_mem[req_key[BW-1:0]];
   end

   // node pool; new node goes at the pool fill point, linked to old head
   always_ff @(posedge clock) begin
      if (ins_ok) begin
         key_mem[count_ff[NW-1:0]]  <= key_ff;
         val_mem[count_ff[NW-1:0]]  <= value_ff;
         next_mem[count_ff[NW-1:0]] <= head_rd_ff;
      end
      if (cmd.load_head || cmd.follow_next) begin
         nkey_rd_ff  <= key_mem[node_ra];
         nval_rd_ff  <= val_mem[node_ra];
         nnext_rd_ff <= next_mem[node_ra];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         key_ff   <= req_key;
         value_ff <= req_value[VW-1:0];
      end
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         count_ff   <= '0;
      end else begin
         if (cmd.clear_step) clr_cnt_ff <= clr_cnt_ff + BW'(1);
         if (ins_ok) count_ff <= count_ff + PW'(1);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_value_out_ff <= '0;
         if (func_ff == FUNC_INSERT) begin
            if (cmd.hit)   rsp_status_ff <= ST_DUP;
            else if (full) rsp_status_ff <= ST_FULL;
            else           rsp_status_ff <= ST_OK;
         end else if (cmd.hit) begin
            rsp_status_ff    <= ST_OK;
            rsp_value_out_ff <= OUT_BITS'(nval_rd_ff);
         end else begin
            rsp_status_ff <= ST_MISS;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_out_ff;

endmodule

// ===== rtl/chained_hash_map.sv =====
// Key-value map with 32-bit keys, separate chaining. The bucket is the low
// log2(BUCKETS) bits of the key; nodes come from a pool of ENTRIES and are
// pushed at the head of their bucket's chain, never freed. A request is taken
// when start is high and busy is low. Each request gives exactly one result,
// shown on rsp_* for one cycle with rsp_valid high; the receiver cannot stall
// it, so it must take every result in that cycle. After reset the block runs
// a clearing pass over the bucket head table and holds busy high until the
// pass is done. Each request then reads its bucket head, then the chain nodes
// one at a time through the single node memory port until the key is found
// or the chain ends (no node for an empty bucket); the next request can be
// accepted only after that. The result appears the cycle busy drops.
module chained_hash_map #(
   parameter int BUCKETS    = 64,     // power of two
   parameter int ENTRIES    = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_func,
   input  logic [chm_pkg::KEY_BITS-1:0] req_key,
   input  logic [chm_pkg::KEY_BITS-1:0] req_value,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [chm_pkg::OUT_BITS-1:0] rsp_value_out
);
   import chm_pkg::*;

   chm_cmd_type cmd;
   chm_sts_type sts;

   // sequencer: clear pass, head read, chain walk, commit
   chm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // tables, node pool, compare and response registers
   chm_datapath #(
      .BUCKETS    (BUCKETS),
      .ENTRIES    (ENTRIES),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_func      (req_func),
      .req_key       (req_key),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out)
   );

endmodule
